// ----- hdl/rmt_pkg.sv -----
// Shared types and constants for the running median tracker.
package rmt_pkg;

    localparam int SAMPLE_W = 32;
    localparam int MEDIAN_W = 33;
    localparam int HELD_W   = 11;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [MEDIAN_W-1:0] median_t;
    typedef logic [HELD_W-1:0]          held_t;

    // Per-cycle operation broadcast to every cell of one chain.
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_SHIFT_IN,
        OP_POP_INSERT
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        sample_t  x;
    } cell_ctl_t;

endpackage

// ----- hdl/running_median_tracker_top.sv -----
// Top level of the running median tracker: two sorted cell chains and result register.
//
// Every accepted sample request that finds room is inserted into a store made of two
// chains of cells that meet at the median. The lower chain holds the smaller half in
// descending order, its head being the largest of that half; the upper chain holds
// the larger half in ascending order, its head the smallest. The upper half holds
// the same number of samples or one more. Each cell compares its entry with the
// broadcast sample and either holds, takes the sample, or takes a neighbor's entry,
// so insertion and rebalancing finish in the same cycle for any CAPACITY. The
// result (twice the median, the held count and the drop flag) is formed from the
// two chain heads once the insertion is registered and the output register is free,
// and held there. A new request can be accepted every cycle unless sample_stall is set;
// each request passes the pending register, then the output register. Once CAPACITY
// samples are held, further samples are dropped, flagged, and the median is reported
// unchanged. The store needs no clearing pass: entries beyond the held count are
// never used. held_count carries the low 11 bits of the count.
module running_median_tracker_top #(
    parameter int CAPACITY = 1024
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  sample_valid,
    output logic                  sample_stall,
    input  rmt_pkg::sample_t      sample,
    output logic                  result_valid,
    input  logic                  result_stall,
    output rmt_pkg::median_t      median_times_two,
    output rmt_pkg::held_t        held_count,
    output logic                  dropped
);

    localparam int CW      = $clog2(CAPACITY + 1);
    localparam int LO_CELLS = CAPACITY / 2;
    localparam int HI_CELLS = CAPACITY - CAPACITY / 2;

    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic               pend_reg;
    logic               pend_next;
    logic               drop_pend_reg;
    logic               drop_pend_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    rmt_pkg::median_t   median_reg;
    rmt_pkg::median_t   median_next;
    rmt_pkg::held_t     held_reg;
    rmt_pkg::held_t     held_next;
    logic               drop_reg;
    logic               drop_next;

    logic [CW-1:0]      lo_size;
    logic [CW-1:0]      hi_size;
    logic               full;
    logic               odd;
    logic               accept;
    logic               out_free;
    rmt_pkg::sample_t   lo_head;
    rmt_pkg::sample_t   hi_head;
    rmt_pkg::cell_ctl_t lo_ctl;
    rmt_pkg::cell_ctl_t hi_ctl;

    // Lower half gets floor(n/2) samples, upper half the rest.
    assign lo_size  = count_reg >> 1;
    assign hi_size  = count_reg - lo_size;
    assign odd      = count_reg[0];
    assign full     = count_reg == CW'(CAPACITY);

    // The output slot frees up when it is empty or its result is taken.
    assign out_free     = !out_valid_reg || !result_stall;
    assign sample_stall = pend_reg && !out_free;
    assign accept       = sample_valid && !sample_stall;

    // Decide per request which chain inserts and whether a head crosses over.
    always_comb
    begin
        lo_ctl.op  = rmt_pkg::OP_HOLD;
        lo_ctl.x   = sample;
        hi_ctl.op  = rmt_pkg::OP_HOLD;
        hi_ctl.x   = sample;
        count_next = count_reg;
        if (accept && !full)
        begin
            count_next = count_reg + 1'b1;
            if (!odd)
            begin
                // Halves equal: upper half must grow.
                if (lo_size == '0 || sample >= lo_head)
                begin
                    hi_ctl.op = rmt_pkg::OP_INSERT;
                end
                else
                begin
                    // Advance the lower head into the upper half.
                    lo_ctl.op = rmt_pkg::OP_POP_INSERT;
                    hi_ctl.op = rmt_pkg::OP_SHIFT_IN;
                end
            end
            else
            begin
                // Upper half is one ahead: lower half must grow.
                if (sample <= hi_head)
                begin
                    lo_ctl.op = rmt_pkg::OP_INSERT;
                end
                else
                begin
                    hi_ctl.op = rmt_pkg::OP_POP_INSERT;
                    lo_ctl.op = rmt_pkg::OP_SHIFT_IN;
                end
            end
        end
    end

    rmt_chain #(
        .N_CELLS    (LO_CELLS),
        .DESCENDING (1'b1),
        .CW         (CW)
    ) u_lo_chain (
        .clk      (clk),
        .ctl      (lo_ctl),
        .size     (lo_size),
        .cross_in (hi_head),
        .head     (lo_head)
    );

    rmt_chain #(
        .N_CELLS    (HI_CELLS),
        .DESCENDING (1'b0),
        .CW         (CW)
    ) u_hi_chain (
        .clk      (clk),
        .ctl      (hi_ctl),
        .size     (hi_size),
        .cross_in (lo_head),
        .head     (hi_head)
    );

    // Pending request moves into the output register as soon as it is free.
    always_comb
    begin
        pend_next      = pend_reg;
        drop_pend_next = drop_pend_reg;
        out_valid_next = out_valid_reg;
        median_next    = median_reg;
        held_next      = held_reg;
        drop_next      = drop_reg;
        if (out_valid_reg && !result_stall)
            out_valid_next = 1'b0;
        if (pend_reg && out_free)
        begin
            out_valid_next = 1'b1;
            pend_next      = 1'b0;
            drop_next      = drop_pend_reg;
            held_next      = rmt_pkg::HELD_W'(count_reg);
            if (odd)
                median_next = {hi_head, 1'b0};
            else
                median_next = $signed({lo_head[rmt_pkg::SAMPLE_W-1], lo_head})
                            + $signed({hi_head[rmt_pkg::SAMPLE_W-1], hi_head});
        end
        if (accept)
        begin
            pend_next      = 1'b1;
            drop_pend_next = full;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        drop_pend_reg <= drop_pend_next;
        median_reg    <= median_next;
        held_reg      <= held_next;
        drop_reg      <= drop_next;
    end

    assign result_valid     = out_valid_reg;
    assign median_times_two = median_reg;
    assign held_count       = held_reg;
    assign dropped          = drop_reg;

endmodule

// ----- hdl/rmt_cell.sv -----
// One sorted-chain cell: holds one sample and trades it with its neighbors.
module rmt_cell #(
    parameter int INDEX      = 0,
    parameter bit DESCENDING = 1'b0,
    parameter int CW         = 11
) (
    input  logic                clk,
    input  rmt_pkg::cell_ctl_t  ctl,
    input  logic [CW-1:0]       size,
    input  rmt_pkg::sample_t    prev_val,
    input  logic                prev_before,
    input  rmt_pkg::sample_t    next_val,
    input  logic                next_before,
    output rmt_pkg::sample_t    val,
    output logic                ahead
);

    rmt_pkg::sample_t val_reg;
    rmt_pkg::sample_t val_next;
    logic             occupied;
    logic             cmp;

    assign occupied = size > CW'(INDEX);
    assign cmp      = DESCENDING ? (val_reg > ctl.x) : (val_reg < ctl.x);
    // Set when this entry sorts ahead of the incoming sample.
    assign ahead    = occupied && cmp;
    assign val      = val_reg;

    always_comb
    begin
        unique case (ctl.op)
            rmt_pkg::OP_HOLD:
            begin
                val_next = val_reg;
            end
            rmt_pkg::OP_INSERT:
            begin
                // Keep, take the new sample, or move one place outward.
                if (ahead)
                    val_next = val_reg;
                else if (prev_before)
                    val_next = ctl.x;
                else
                    val_next = prev_val;
            end
            rmt_pkg::OP_SHIFT_IN:
            begin
                val_next = prev_val;
            end
            rmt_pkg::OP_POP_INSERT:
            begin
                // Head leaves; close the gap and drop the new sample in.
                if (next_before)
                    val_next = next_val;
                else if (ahead)
                    val_next = ctl.x;
                else
                    val_next = val_reg;
            end
            default:
            begin
                val_next = val_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

// ----- hdl/rmt_chain.sv -----
// Row of sorted cells forming one half of the tracked multiset.
module rmt_chain #(
    parameter int N_CELLS    = 512,
    parameter bit DESCENDING = 1'b0,
    parameter int CW         = 11
) (
    input  logic                clk,
    input  rmt_pkg::cell_ctl_t  ctl,
    input  logic [CW-1:0]       size,
    input  rmt_pkg::sample_t    cross_in,
    output rmt_pkg::sample_t    head
);

    rmt_pkg::sample_t vals [N_CELLS];
    logic             befs [N_CELLS];

    assign head = vals[0];

    for (genvar i = 0; i < N_CELLS; i++)
    begin : g_cell
        rmt_pkg::sample_t pv;
        rmt_pkg::sample_t nv;
        logic             pb;
        logic             nb;

        if (i == 0)
        begin : g_first
            // Cell 0 takes the value handed across from the other half, and
            // takes the new sample on insert whenever its own entry does not sort ahead.
            assign pv = cross_in;
            assign pb = 1'b1;
        end
        else
        begin : g_mid
            assign pv = vals[i-1];
            assign pb = befs[i-1];
        end

        if (i == N_CELLS - 1)
        begin : g_last
            assign nv = '0;
            assign nb = 1'b0;
        end
        else
        begin : g_inner
            assign nv = vals[i+1];
            assign nb = befs[i+1];
        end

        rmt_cell #(
            .INDEX      (i),
            .DESCENDING (DESCENDING),
            .CW         (CW)
        ) u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .size        (size),
            .prev_val    (pv),
            .prev_before (pb),
            .next_val    (nv),
            .next_before (nb),
            .val         (vals[i]),
            .ahead       (befs[i])
        );
    end

endmodule

// ----- hdl/rmt_checker.sv -----
// Port-level checker for the running median tracker and its bind.
module rmt_checker #(
    parameter int CAPACITY = 1024
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             result_valid,
    input  logic             result_stall,
    input  rmt_pkg::median_t median_times_two,
    input  rmt_pkg::held_t   held_count,
    input  logic             dropped
);

    // A dropped sample means the store was full.
    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && dropped |-> held_count == rmt_pkg::HELD_W'(CAPACITY))
        else $error("dropped result without a full store");

    // With an odd count the median is a held sample, so its double is even.
    a_odd_even: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && held_count[0] |-> !median_times_two[0])
        else $error("odd count gave a half-step median");

    // A stalled result stays in place.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(median_times_two)
            && $stable(held_count) && $stable(dropped))
        else $error("stalled result changed");

endmodule

bind running_median_tracker_top rmt_checker #(
    .CAPACITY (CAPACITY)
) u_rmt_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .median_times_two (median_times_two),
    .held_count       (held_count),
    .dropped          (dropped)
);
